FILE: sv/fifo_ready_and_blocked_queues_macros.svh
// Assertion macros shared by the scheduler RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef FIFO_READY_AND_BLOCKED_QUEUES_MACROS_SVH
`define FIFO_READY_AND_BLOCKED_QUEUES_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low)
`define FRQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low)
`define FRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/frq_pkg.sv
// Shared constants, codes and controller/datapath types for the thread scheduler.
// No dependencies.
package frq_pkg;

    // queue sizes
    localparam int READY_DEPTH   = 16;
    localparam int BLOCKED_DEPTH = 16;

    // field widths
    localparam int ID_W      = 16;
    localparam int CMD_W     = 3;
    localparam int ST_W      = 2;
    localparam int CNT_OUT_W = 5;

    // pointer and occupancy widths
    localparam int RPTR_W = $clog2(READY_DEPTH);
    localparam int RCNT_W = $clog2(READY_DEPTH + 1);
    localparam int BPTR_W = $clog2(BLOCKED_DEPTH);
    localparam int BCNT_W = $clog2(BLOCKED_DEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 3'd0,
        CMD_BLOCK  = 3'd1,
        CMD_YIELD  = 3'd2,
        CMD_TERM   = 3'd3,
        CMD_RESUME = 3'd4
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // ready RAM read address select (offset from head)
    typedef enum logic [1:0] {
        RD_HEAD = 2'd0,
        RD_NEXT = 2'd1,
        RD_SKIP = 2'd2
    } t_rd_sel;

    // controller -> datapath commands
    typedef struct packed {
        logic    in_ready;
        logic    r_push_id;
        logic    r_push_moved;
        logic    r_shift_wr;
        logic    r_pop;
        logic    r_drop_tail;
        logic    b_push;
        logic    b_pop;
        t_rd_sel rd_sel;
        logic    q_clr;
        logic    q_inc;
        logic    set_st;
        t_status st;
        logic    set_dispatch;
        logic    set_moved;
        logic    res_load;
    } t_frq_ctl;

    // datapath -> controller status
    typedef struct packed {
        logic             in_valid;
        logic [CMD_W-1:0] cmd;
        logic             disk;
        logic             r_full;
        logic             r_empty;
        logic             r_will_full;
        logic             b_full;
        logic             b_empty;
        logic             match;
        logic             last;
        logic             shift_last;
        logic             out_free;
    } t_frq_stat;

endpackage

FILE: sv/frq_if.sv
// Valid/ready channel interfaces for scheduler commands and results.
// Depends on frq_pkg.
interface frq_cmd_if;
    import frq_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  thread_id;
    logic             disk_ready;

    modport source (output valid, output cmd, output thread_id, output disk_ready,
                    input ready);
    modport sink   (input valid, input cmd, input thread_id, input disk_ready,
                    output ready);
endinterface

interface frq_res_if;
    import frq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ST_W-1:0]      status;
    logic                 dispatch_valid;
    logic [ID_W-1:0]      dispatch_id;
    logic                 moved_valid;
    logic [ID_W-1:0]      moved_id;
    logic [CNT_OUT_W-1:0] ready_count;
    logic [CNT_OUT_W-1:0] blocked_count;

    modport source (output valid, output status, output dispatch_valid, output dispatch_id,
                    output moved_valid, output moved_id, output ready_count,
                    output blocked_count, input ready);
    modport sink   (input valid, input status, input dispatch_valid, input dispatch_id,
                    input moved_valid, input moved_id, input ready_count,
                    input blocked_count, output ready);
endinterface

FILE: sv/frq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module frq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/frq_dp.sv
// Scheduler datapath: queue RAMs, head pointers, counts, result and output registers.
// Depends on frq_pkg, frq_if, frq_ram and the assertion macro header.
`include "fifo_ready_and_blocked_queues_macros.svh"

module frq_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  frq_pkg::t_frq_ctl i_ctl,
    output frq_pkg::t_frq_stat o_stat,
    frq_cmd_if.sink           i_cmd,
    frq_res_if.source         o_res
);
    import frq_pkg::*;

    // queue position (offset from head) to RAM address, one compare and subtract
    function automatic logic [RPTR_W-1:0] f_raddr(input logic [RPTR_W-1:0] head,
                                                  input logic [RCNT_W-1:0] ofs);
        logic [RCNT_W:0] sum;
        sum = (RCNT_W+1)'(head) + (RCNT_W+1)'(ofs);
        if (sum >= (RCNT_W+1)'(READY_DEPTH)) begin
            sum = sum - (RCNT_W+1)'(READY_DEPTH);
        end
        return sum[RPTR_W-1:0];
    endfunction

    function automatic logic [BPTR_W-1:0] f_baddr(input logic [BPTR_W-1:0] head,
                                                  input logic [BCNT_W-1:0] ofs);
        logic [BCNT_W:0] sum;
        sum = (BCNT_W+1)'(head) + (BCNT_W+1)'(ofs);
        if (sum >= (BCNT_W+1)'(BLOCKED_DEPTH)) begin
            sum = sum - (BCNT_W+1)'(BLOCKED_DEPTH);
        end
        return sum[BPTR_W-1:0];
    endfunction

    // latched command
    logic [CMD_W-1:0] r_cmd;
    logic [ID_W-1:0]  r_id;
    logic             r_disk;
    logic             w_accept;

    // queue control state
    logic [RPTR_W-1:0] r_rhead, n_rhead;
    logic [RCNT_W-1:0] r_rcnt, n_rcnt;
    logic [BPTR_W-1:0] r_bhead, n_bhead;
    logic [BCNT_W-1:0] r_bcnt, n_bcnt;
    logic [RCNT_W-1:0] r_q, n_q;

    // RAM ports
    logic              w_r_we;
    logic [RPTR_W-1:0] w_r_waddr;
    logic [ID_W-1:0]   w_r_wdata;
    logic [RPTR_W-1:0] w_r_raddr;
    logic [ID_W-1:0]   w_r_rdata;
    logic [BPTR_W-1:0] w_b_waddr;
    logic [ID_W-1:0]   w_b_rdata;

    // working result
    t_status         r_status;
    logic            r_dval;
    logic [ID_W-1:0] r_did;
    logic            r_mval;
    logic [ID_W-1:0] r_mid;

    // output register
    logic                 r_out_valid;
    t_status              r_out_status;
    logic                 r_out_dval;
    logic [ID_W-1:0]      r_out_did;
    logic                 r_out_mval;
    logic [ID_W-1:0]      r_out_mid;
    logic [CNT_OUT_W-1:0] r_out_rcnt;
    logic [CNT_OUT_W-1:0] r_out_bcnt;

    logic [RCNT_W:0] w_q_ext;

    assign w_accept    = i_ctl.in_ready && i_cmd.valid;
    assign i_cmd.ready = i_ctl.in_ready;

    // command capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_cmd.cmd;
            r_id   <= i_cmd.thread_id;
            r_disk <= i_cmd.disk_ready;
        end
    end

    // ready RAM write and read addressing
    always_comb begin
        w_r_we    = i_ctl.r_push_id || i_ctl.r_push_moved || i_ctl.r_shift_wr;
        w_r_waddr = i_ctl.r_shift_wr ? f_raddr(r_rhead, r_q) : f_raddr(r_rhead, r_rcnt);
        w_r_wdata = r_id;
        if (i_ctl.r_push_moved) begin
            w_r_wdata = w_b_rdata;
        end else if (i_ctl.r_shift_wr) begin
            w_r_wdata = w_r_rdata;
        end
        unique case (i_ctl.rd_sel)
            RD_HEAD: w_r_raddr = r_rhead;
            RD_NEXT: w_r_raddr = f_raddr(r_rhead, RCNT_W'(r_q + RCNT_W'(1)));
            RD_SKIP: w_r_raddr = f_raddr(r_rhead, RCNT_W'(r_q + RCNT_W'(2)));
            default: w_r_raddr = r_rhead;
        endcase
    end

    assign w_b_waddr = f_baddr(r_bhead, r_bcnt);

    frq_ram #(.WIDTH(ID_W), .DEPTH(READY_DEPTH)) u_ready_ram (
        .i_clk   (i_clk),
        .i_we    (w_r_we),
        .i_waddr (w_r_waddr),
        .i_wdata (w_r_wdata),
        .i_raddr (w_r_raddr),
        .o_rdata (w_r_rdata)
    );

    frq_ram #(.WIDTH(ID_W), .DEPTH(BLOCKED_DEPTH)) u_blocked_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.b_push),
        .i_waddr (w_b_waddr),
        .i_wdata (r_id),
        .i_raddr (r_bhead),
        .o_rdata (w_b_rdata)
    );

    // pointer, count and scan position updates
    always_comb begin
        n_rhead = r_rhead;
        n_rcnt  = r_rcnt;
        n_bhead = r_bhead;
        n_bcnt  = r_bcnt;
        n_q     = r_q;
        priority if (i_ctl.r_push_id || i_ctl.r_push_moved) begin
            n_rcnt = r_rcnt + RCNT_W'(1);
        end else if (i_ctl.r_pop) begin
            n_rcnt  = r_rcnt - RCNT_W'(1);
            n_rhead = (r_rhead == RPTR_W'(READY_DEPTH - 1)) ? '0 : r_rhead + RPTR_W'(1);
        end else if (i_ctl.r_drop_tail) begin
            n_rcnt = r_rcnt - RCNT_W'(1);
        end
        if (i_ctl.b_push) begin
            n_bcnt = r_bcnt + BCNT_W'(1);
        end else if (i_ctl.b_pop) begin
            n_bcnt  = r_bcnt - BCNT_W'(1);
            n_bhead = (r_bhead == BPTR_W'(BLOCKED_DEPTH - 1)) ? '0 : r_bhead + BPTR_W'(1);
        end
        if (i_ctl.q_clr) begin
            n_q = '0;
        end else if (i_ctl.q_inc) begin
            n_q = r_q + RCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rhead <= '0;
            r_rcnt  <= '0;
            r_bhead <= '0;
            r_bcnt  <= '0;
            r_q     <= '0;
        end else begin
            r_rhead <= n_rhead;
            r_rcnt  <= n_rcnt;
            r_bhead <= n_bhead;
            r_bcnt  <= n_bcnt;
            r_q     <= n_q;
        end
    end

    // working result fields, cleared on each new transfer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= ST_OK;
            r_dval   <= 1'b0;
            r_did    <= '0;
            r_mval   <= 1'b0;
            r_mid    <= '0;
        end else begin
            if (i_ctl.set_st) begin
                r_status <= i_ctl.st;
            end
            if (i_ctl.set_dispatch) begin
                r_dval <= 1'b1;
                r_did  <= w_r_rdata;
            end
            if (i_ctl.set_moved) begin
                r_mval <= 1'b1;
                r_mid  <= w_b_rdata;
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.res_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.res_load) begin
            r_out_status <= r_status;
            r_out_dval   <= r_dval;
            r_out_did    <= r_did;
            r_out_mval   <= r_mval;
            r_out_mid    <= r_mid;
            r_out_rcnt   <= CNT_OUT_W'(r_rcnt);
            r_out_bcnt   <= CNT_OUT_W'(r_bcnt);
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_out_status;
    assign o_res.dispatch_valid = r_out_dval;
    assign o_res.dispatch_id    = r_out_did;
    assign o_res.moved_valid    = r_out_mval;
    assign o_res.moved_id       = r_out_mid;
    assign o_res.ready_count    = r_out_rcnt;
    assign o_res.blocked_count  = r_out_bcnt;

    // status to controller
    assign w_q_ext = (RCNT_W+1)'(r_q);

    always_comb begin
        o_stat.in_valid    = i_cmd.valid;
        o_stat.cmd         = r_cmd;
        o_stat.disk        = r_disk;
        o_stat.r_full      = (r_rcnt == RCNT_W'(READY_DEPTH));
        o_stat.r_empty     = (r_rcnt == '0);
        o_stat.r_will_full = (r_rcnt == RCNT_W'(READY_DEPTH - 1));
        o_stat.b_full      = (r_bcnt == BCNT_W'(BLOCKED_DEPTH));
        o_stat.b_empty     = (r_bcnt == '0);
        o_stat.match       = (w_r_rdata == r_id);
        o_stat.last        = (w_q_ext + (RCNT_W+1)'(1) == (RCNT_W+1)'(r_rcnt));
        o_stat.shift_last  = (w_q_ext + (RCNT_W+1)'(2) == (RCNT_W+1)'(r_rcnt));
        o_stat.out_free    = !r_out_valid || o_res.ready;
    end

    // checks
    `FRQ_ASSERT_IMPL(a_push_not_full, i_clk, i_rst_n, i_ctl.r_push_id || i_ctl.r_push_moved, r_rcnt != RCNT_W'(READY_DEPTH), "ready push into full queue")
    `FRQ_ASSERT_IMPL(a_remove_not_empty, i_clk, i_rst_n, i_ctl.r_pop || i_ctl.r_drop_tail, r_rcnt != '0, "ready removal from empty queue")
    `FRQ_ASSERT_IMPL(a_one_ready_change, i_clk, i_rst_n, 1'b1, $onehot0({i_ctl.r_push_id, i_ctl.r_push_moved, i_ctl.r_pop, i_ctl.r_drop_tail}), "two ready queue updates in one cycle")
    `FRQ_ASSERT_NEXT(a_move_grows_ready, i_clk, i_rst_n, i_ctl.r_push_moved, r_rcnt == RCNT_W'($past(r_rcnt) + RCNT_W'(1)), "moved id did not grow ready queue")
    `FRQ_ASSERT_IMPL(a_dispatch_ok, i_clk, i_rst_n, r_out_valid && r_out_dval, r_out_status == ST_OK, "dispatch with error status")

endmodule

FILE: sv/frq_ctrl.sv
// Scheduler controller: one-hot state machine sequencing each command.
// Depends on frq_pkg.
module frq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  frq_pkg::t_frq_stat i_stat,
    output frq_pkg::t_frq_ctl  o_ctl
);
    import frq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_YREAD  = 7'b0000100,
        S_MREAD  = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_SHIFT  = 7'b0100000,
        S_FINISH = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // next state and command decode
    always_comb begin
        n_state      = r_state;
        o_ctl        = '0;
        o_ctl.rd_sel = RD_HEAD;
        o_ctl.st     = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                o_ctl.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FINISH;
                unique case (i_stat.cmd)
                    CMD_ADD: begin
                        if (i_stat.r_full) begin
                            o_ctl.set_st = 1'b1;
                            o_ctl.st     = ST_FULL;
                        end else begin
                            o_ctl.r_push_id = 1'b1;
                        end
                    end
                    CMD_BLOCK: begin
                        if (i_stat.b_full) begin
                            o_ctl.set_st = 1'b1;
                            o_ctl.st     = ST_FULL;
                        end else begin
                            o_ctl.b_push = 1'b1;
                        end
                    end
                    CMD_YIELD: begin
                        if (i_stat.r_empty) begin
                            o_ctl.set_st = 1'b1;
                            o_ctl.st     = ST_EMPTY;
                        end else begin
                            n_state = S_YREAD;
                        end
                    end
                    CMD_TERM: begin
                        if (i_stat.r_empty) begin
                            o_ctl.set_st = 1'b1;
                            o_ctl.st     = ST_EMPTY;
                        end else begin
                            o_ctl.q_clr = 1'b1;
                            n_state     = S_SCAN;
                        end
                    end
                    CMD_RESUME: begin
                        if (i_stat.r_full) begin
                            o_ctl.set_st = 1'b1;
                            o_ctl.st     = ST_FULL;
                        end else begin
                            o_ctl.r_push_id = 1'b1;
                            if (i_stat.disk && !i_stat.b_empty) begin
                                // id fits but the moved head would not
                                if (i_stat.r_will_full) begin
                                    o_ctl.set_st = 1'b1;
                                    o_ctl.st     = ST_FULL;
                                end else begin
                                    n_state = S_MREAD;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_YREAD: begin
                o_ctl.set_dispatch = 1'b1;
                o_ctl.r_pop        = 1'b1;
                n_state            = S_FINISH;
            end
            S_MREAD: begin
                o_ctl.r_push_moved = 1'b1;
                o_ctl.b_pop        = 1'b1;
                o_ctl.set_moved    = 1'b1;
                n_state            = S_FINISH;
            end
            S_SCAN: begin
                // compare entry at r_q while fetching the next one
                o_ctl.rd_sel = RD_NEXT;
                if (i_stat.match) begin
                    if (i_stat.last) begin
                        o_ctl.r_drop_tail = 1'b1;
                        n_state           = S_FINISH;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else if (i_stat.last) begin
                    o_ctl.set_st = 1'b1;
                    o_ctl.st     = ST_NOTFOUND;
                    n_state      = S_FINISH;
                end else begin
                    o_ctl.q_inc = 1'b1;
                end
            end
            S_SHIFT: begin
                // move entry q+1 down to q, fetch q+2
                o_ctl.r_shift_wr = 1'b1;
                o_ctl.rd_sel     = RD_SKIP;
                if (i_stat.shift_last) begin
                    o_ctl.r_drop_tail = 1'b1;
                    n_state           = S_FINISH;
                end else begin
                    o_ctl.q_inc = 1'b1;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_ctl.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: sv/fifo_ready_and_blocked_queues.sv
// Thread scheduler with FIFO ready and blocked queues of 16-bit thread ids.
// Top level: joins frq_ctrl and frq_dp; depends on frq_pkg and frq_if.
//
// One command per transfer on i_cmd, one result per command on o_res. Both queues are
// circular buffers held in RAM with a head pointer and an occupancy count, so nothing
// needs clearing after reset. The result is loaded into the output register straight
// after the decode state for add, block, a resume that moves nothing, the unused codes
// and any rejected command; yield and a resume that moves a blocked entry first pass
// through a read state. Terminate walks the ready queue one entry per cycle through the
// single RAM read port and then closes any gap one entry per cycle before its result is
// loaded. A new command can be taken in the cycle after the previous result is loaded,
// while that result may still wait in the output register; none is taken before that
// load. The load itself waits for as long as the output register holds a result not
// yet taken.
module fifo_ready_and_blocked_queues (
    input  logic      i_clk,
    input  logic      i_rst_n,
    frq_cmd_if.sink   i_cmd,
    frq_res_if.source o_res
);
    import frq_pkg::*;

    t_frq_ctl  w_ctl;
    t_frq_stat w_stat;

    // sequencer
    frq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl)
    );

    // queues and result path
    frq_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_stat  (w_stat),
        .i_cmd   (i_cmd),
        .o_res   (o_res)
    );

endmodule
